// ----- hw/rtl/qse_pkg.sv -----
package qse_pkg;

  localparam logic [7:0] QUOTE_CHAR  = 8'h22;
  localparam logic [7:0] APOS_CHAR   = 8'h27;
  localparam logic [7:0] BSLASH_CHAR = 8'h5C;
  localparam logic [7:0] X_CHAR      = 8'h78;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;

  typedef enum logic [1:0] {
    BODY_NONE  = 2'd0,
    BODY_PLAIN = 2'd1,
    BODY_ESC   = 2'd2,
    BODY_HEX   = 2'd3
  } body_kind_t;

  // everything the back end needs to emit the bytes of one input item
  typedef struct packed {
    logic       open_q;
    body_kind_t kind;
    logic [7:0] body;
    logic       close_q;
  } plan_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h57 + {4'd0, nib};
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/qse_front.sv -----
module qse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          end_of_string,
  input  logic          empty_string,
  output qse_pkg::plan_t plan
);

  logic inside_string;
  logic inside_string_next;
  logic [7:0] letter;
  logic       simple;

  always_comb begin
    simple = 1'b1;
    letter = data_byte;
    unique case (data_byte)
      8'h0A: letter = 8'h6E;
      8'h09: letter = 8'h74;
      8'h0D: letter = 8'h72;
      8'h00: letter = 8'h30;
      8'h0C: letter = 8'h66;
      qse_pkg::BSLASH_CHAR, qse_pkg::QUOTE_CHAR, qse_pkg::APOS_CHAR: letter = data_byte;
      default: simple = 1'b0;
    endcase
  end

  always_comb begin
    plan.open_q  = !inside_string;
    plan.body    = data_byte;
    plan.close_q = end_of_string;
    inside_string_next = !end_of_string;
    if (empty_string) begin
      plan.kind          = qse_pkg::BODY_NONE;
      plan.close_q       = 1'b1;
      inside_string_next = 1'b0;
    end else if (simple) begin
      plan.kind = qse_pkg::BODY_ESC;
      plan.body = letter;
    end else if (data_byte >= qse_pkg::PRINT_LO && data_byte <= qse_pkg::PRINT_HI) begin
      plan.kind = qse_pkg::BODY_PLAIN;
    end else begin
      plan.kind = qse_pkg::BODY_HEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_string <= 1'b0;
    end else if (take) begin
      inside_string <= inside_string_next;
    end
  end

endmodule

// ----- hw/rtl/qse_queue.sv -----
module qse_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qse_pkg::plan_t push_plan,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output qse_pkg::plan_t head_plan
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qse_pkg::plan_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_plan  = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/qse_back.sv -----
module qse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  qse_pkg::plan_t head_plan,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_of_run,
  output logic           string_done
);

  localparam logic [2:0] PH_OPEN  = 3'd0;
  localparam logic [2:0] PH_B0    = 3'd1;
  localparam logic [2:0] PH_B1    = 3'd2;
  localparam logic [2:0] PH_B2    = 3'd3;
  localparam logic [2:0] PH_B3    = 3'd4;
  localparam logic [2:0] PH_CLOSE = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  logic       started;
  logic [2:0] phase;
  logic [2:0] cur;
  logic [2:0] nxt;
  logic [2:0] after_body;
  logic [7:0] byte_now;
  logic       emit;

  assign after_body = head_plan.close_q ? PH_CLOSE : PH_DONE;

  always_comb begin
    if (started) begin
      cur = phase;
    end else if (head_plan.open_q) begin
      cur = PH_OPEN;
    end else if (head_plan.kind != qse_pkg::BODY_NONE) begin
      cur = PH_B0;
    end else begin
      cur = PH_CLOSE;
    end
  end

  always_comb begin
    nxt      = PH_DONE;
    byte_now = qse_pkg::QUOTE_CHAR;
    unique case (cur)
      PH_OPEN: begin
        nxt = (head_plan.kind != qse_pkg::BODY_NONE) ? PH_B0 : PH_CLOSE;
      end
      PH_B0: begin
        byte_now = (head_plan.kind == qse_pkg::BODY_PLAIN) ? head_plan.body
                                                           : qse_pkg::BSLASH_CHAR;
        nxt = (head_plan.kind == qse_pkg::BODY_PLAIN) ? after_body : PH_B1;
      end
      PH_B1: begin
        byte_now = (head_plan.kind == qse_pkg::BODY_HEX) ? qse_pkg::X_CHAR : head_plan.body;
        nxt = (head_plan.kind == qse_pkg::BODY_HEX) ? PH_B2 : after_body;
      end
      PH_B2: begin
        byte_now = qse_pkg::hex_digit(head_plan.body[7:4]);
        nxt      = PH_B3;
      end
      PH_B3: begin
        byte_now = qse_pkg::hex_digit(head_plan.body[3:0]);
        nxt      = after_body;
      end
      PH_CLOSE: begin
        nxt = PH_DONE;
      end
      default: begin
        nxt = PH_DONE;
      end
    endcase
  end

  // output register doubles as the slot that frees the sequencer from the receiver
  assign emit = head_valid && (!out_valid || out_ready);
  assign pop  = emit && (nxt == PH_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      phase     <= PH_OPEN;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        started <= (nxt != PH_DONE);
        phase   <= nxt;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= byte_now;
      last_of_run <= (nxt == PH_DONE);
      string_done <= (cur == PH_CLOSE);
    end
  end

endmodule

// ----- hw/rtl/quoted_string_escaper.sv -----
// quoted_string_escaper: turns raw string bytes into quoted, C-style escaped text
//
// input channel (in_valid/in_ready): one raw byte per transfer with end_of_string
// on the last byte, or empty_string for a zero-length string
// output channel (out_valid/out_ready): one text byte per transfer; last_of_run
// marks the final byte caused by an input, string_done marks the closing quote
//
// the front end classifies each byte and queues a short plan; the back end
// sequencer emits one byte per cycle from the head plan while the receiver is
// ready, so an input yields one to six output bytes (printable text one, escapes
// two, hex escapes four, plus one per quote). the single output byte per cycle
// sets the rate
//
// the front keeps taking input while the queue (QUEUE_DEPTH plans) has room,
// so a stalled receiver only stops input once the queue fills
// reset empties the queue and output register and closes any open string
module quoted_string_escaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  input  logic       empty_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       string_done
);

  qse_pkg::plan_t new_plan;
  qse_pkg::plan_t head_plan;
  logic           full;
  logic           take;
  logic           pop;
  logic           head_valid;

  assign in_ready = !full;
  assign take     = in_valid && !full;

  qse_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .empty_string  (empty_string),
    .plan          (new_plan)
  );

  qse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_plan  (new_plan),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_plan  (head_plan)
  );

  qse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_plan   (head_plan),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .string_done (string_done)
  );

endmodule
